@@ design/dsrc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsrc_pkg
// Shared types and constants of the dense to sparse row compressor.
// ----------------------------------------------------------------------------
package dsrc_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int QUEUE_DEPTH = 4;

  localparam int ELEM_W  = 64;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 10;
  localparam int SLOT_W  = 20;
  localparam int PTR_W   = 21;
  localparam int KIND_W  = 2;
  localparam int CIDX_W  = 2;

  localparam int DIM_CAP_INT = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
  localparam logic [CFG_W-1:0] DIM_CAP = CFG_W'(DIM_CAP_INT);

  localparam logic [CIDX_W-1:0] CFG_ROW_COUNT      = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_COL_COUNT      = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SYMMETRIC_MODE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROW_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIAG    = 2'd2;

  typedef enum logic [1:0] {
    OP_ENTRY,
    OP_ROW_END,
    OP_ENTRY_ROW_END,
    OP_ROW_END_DIAG
  } op_kind_t;

  typedef struct packed {
    op_kind_t            op;
    logic [ELEM_W-1:0]   bits;
    logic [IDX_W-1:0]    col;
    logic [IDX_W-1:0]    row;
    logic [SLOT_W-1:0]   slot;
    logic [PTR_W-1:0]    ptr;
  } op_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ design/dense_to_sparse_row_compressor_unit.sv @@
// ----------------------------------------------------------------------------
// dense_to_sparse_row_compressor_unit
// Converts a stream of dense double elements into CSR or SSS result words.
// ----------------------------------------------------------------------------
// Path: the accepting edge writes the element's operation word into the
// operation queue, and its first result word is then loaded into the output
// register once that register is free.
// Throughput: one element per cycle while the operation queue is not full;
// an element with two results fills the output register twice, so a run of
// such elements stalls the input once the operation queue is full.
// Reset: counters and queue cleared, row and column counts 1, CSR mode.
module dense_to_sparse_row_compressor_unit #(
  parameter int QUEUE_DEPTH = dsrc_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dsrc_pkg::ELEM_W-1:0]   in_element_bits,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsrc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [dsrc_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsrc_pkg::KIND_W-1:0]   out_result_kind,
  output logic [dsrc_pkg::ELEM_W-1:0]   out_value_bits,
  output logic [dsrc_pkg::IDX_W-1:0]    out_column_index,
  output logic [dsrc_pkg::IDX_W-1:0]    out_row_index,
  output logic [dsrc_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [dsrc_pkg::PTR_W-1:0]    out_row_ptr,
  output logic                          out_last_of_item
);
  import dsrc_pkg::*;

  logic       push;
  logic       pop;
  op_word_t   push_word;
  op_word_t   head_word;
  q_status_t  q_status;

  dsrc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_element_bits (in_element_bits),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_status        (q_status),
    .push            (push),
    .push_word       (push_word)
  );

  dsrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_status  (q_status)
  );

  dsrc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_word        (head_word),
    .q_status         (q_status),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_value_bits   (out_value_bits),
    .out_column_index (out_column_index),
    .out_row_index    (out_row_index),
    .out_slot_index   (out_slot_index),
    .out_row_ptr      (out_row_ptr),
    .out_last_of_item (out_last_of_item)
  );

endmodule

@@ design/dsrc_front.sv @@
// ----------------------------------------------------------------------------
// dsrc_front
// Holds the configuration and the row, column and nonzero counters; turns
// each nonzero or row-ending element into one queued operation word.
// ----------------------------------------------------------------------------
module dsrc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dsrc_pkg::ELEM_W-1:0]   in_element_bits,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsrc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [dsrc_pkg::CFG_W-1:0]    cfg_data,
  input  dsrc_pkg::q_status_t           q_status,
  output logic                          push,
  output dsrc_pkg::op_word_t            push_word
);
  import dsrc_pkg::*;

  logic [CFG_W-1:0]  row_count_r;
  logic [CFG_W-1:0]  col_count_r;
  logic              symmetric_r;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [PTR_W-1:0]  total_r, total_nxt;

  logic              accept;
  logic              nonzero;
  logic [CFG_W-1:0]  rows_clamped, cols_clamped;
  logic [CFG_W-1:0]  rows_last, cols_last;
  logic              row_end;
  logic              matrix_end;
  logic [PTR_W-1:0]  total_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign nonzero   = (in_element_bits[ELEM_W-2:0] != '0);
  assign total_inc = total_r + PTR_W'(1);

  always_comb begin
    rows_clamped = row_count_r;
    if (row_count_r == '0) begin
      rows_clamped = CFG_W'(1);
    end else if (row_count_r > DIM_CAP) begin
      rows_clamped = DIM_CAP;
    end
    cols_clamped = col_count_r;
    if (col_count_r == '0) begin
      cols_clamped = CFG_W'(1);
    end else if (col_count_r > DIM_CAP) begin
      cols_clamped = DIM_CAP;
    end
  end

  assign rows_last  = rows_clamped - CFG_W'(1);
  assign cols_last  = cols_clamped - CFG_W'(1);
  assign matrix_end = ({1'b0, row_r} >= rows_last);
  assign row_end    = symmetric_r ? (col_r >= row_r) : ({1'b0, col_r} >= cols_last);

  always_comb begin
    row_nxt         = row_r;
    col_nxt         = col_r;
    total_nxt       = total_r;
    push            = 1'b0;
    push_word.op    = OP_ENTRY;
    push_word.bits  = in_element_bits;
    push_word.col   = col_r;
    push_word.row   = row_r;
    push_word.slot  = total_r[SLOT_W-1:0];
    push_word.ptr   = total_r;
    if (accept) begin
      if (symmetric_r) begin
        if (row_end) begin
          push         = 1'b1;
          push_word.op = OP_ROW_END_DIAG;
        end else if (nonzero) begin
          push         = 1'b1;
          push_word.op = OP_ENTRY;
          total_nxt    = total_inc;
        end
      end else begin
        if (nonzero && row_end) begin
          push          = 1'b1;
          push_word.op  = OP_ENTRY_ROW_END;
          push_word.ptr = total_inc;
          total_nxt     = total_inc;
        end else if (nonzero) begin
          push         = 1'b1;
          push_word.op = OP_ENTRY;
          total_nxt    = total_inc;
        end else if (row_end) begin
          push         = 1'b1;
          push_word.op = OP_ROW_END;
        end
      end
      if (row_end) begin
        col_nxt = '0;
        if (matrix_end) begin
          row_nxt   = '0;
          total_nxt = '0;
        end else begin
          row_nxt = row_r + IDX_W'(1);
        end
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_W'(1);
      col_count_r <= CFG_W'(1);
      symmetric_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      total_r     <= '0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      total_r <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROW_COUNT:      row_count_r <= cfg_data;
          CFG_COL_COUNT:      col_count_r <= cfg_data;
          CFG_SYMMETRIC_MODE: symmetric_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ design/dsrc_queue.sv @@
// ----------------------------------------------------------------------------
// dsrc_queue
// Short first-in first-out queue of operation words between front and back.
// ----------------------------------------------------------------------------
module dsrc_queue #(
  parameter int DEPTH = dsrc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dsrc_pkg::op_word_t   push_word,
  input  logic                 pop,
  output dsrc_pkg::op_word_t   head_word,
  output dsrc_pkg::q_status_t  q_status
);
  import dsrc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_word_t        store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign head_word      = store_r[rd_ptr_r];
  assign q_status.full  = (count_r == CW'(DEPTH));
  assign q_status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ design/dsrc_back.sv @@
// ----------------------------------------------------------------------------
// dsrc_back
// Expands each queued operation word into one or two result words and holds
// them in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module dsrc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsrc_pkg::op_word_t            head_word,
  input  dsrc_pkg::q_status_t           q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsrc_pkg::KIND_W-1:0]   out_result_kind,
  output logic [dsrc_pkg::ELEM_W-1:0]   out_value_bits,
  output logic [dsrc_pkg::IDX_W-1:0]    out_column_index,
  output logic [dsrc_pkg::IDX_W-1:0]    out_row_index,
  output logic [dsrc_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [dsrc_pkg::PTR_W-1:0]    out_row_ptr,
  output logic                          out_last_of_item
);
  import dsrc_pkg::*;

  logic               valid_r;
  logic               phase_r, phase_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ELEM_W-1:0]  bits_r, bits_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic [IDX_W-1:0]   row_r;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic               last_r, last_nxt;

  logic               load;
  logic               take;
  logic               two_words;

  assign load      = !valid_r || !out_stall;
  assign take      = load && !q_status.empty;
  assign two_words = (head_word.op == OP_ENTRY_ROW_END) || (head_word.op == OP_ROW_END_DIAG);
  assign pop       = take && (!two_words || phase_r);
  assign phase_nxt = take ? (two_words && !phase_r) : phase_r;

  always_comb begin
    kind_nxt = KIND_ENTRY;
    bits_nxt = '0;
    col_nxt  = '0;
    slot_nxt = '0;
    ptr_nxt  = '0;
    last_nxt = 1'b1;
    unique case (head_word.op)
      OP_ENTRY: begin
        bits_nxt = head_word.bits;
        col_nxt  = head_word.col;
        slot_nxt = head_word.slot;
      end
      OP_ROW_END: begin
        kind_nxt = KIND_ROW_END;
        ptr_nxt  = head_word.ptr;
      end
      OP_ENTRY_ROW_END: begin
        if (!phase_r) begin
          bits_nxt = head_word.bits;
          col_nxt  = head_word.col;
          slot_nxt = head_word.slot;
          last_nxt = 1'b0;
        end else begin
          kind_nxt = KIND_ROW_END;
          ptr_nxt  = head_word.ptr;
        end
      end
      OP_ROW_END_DIAG: begin
        if (!phase_r) begin
          kind_nxt = KIND_ROW_END;
          ptr_nxt  = head_word.ptr;
          last_nxt = 1'b0;
        end else begin
          kind_nxt = KIND_DIAG;
          bits_nxt = head_word.bits;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= !q_status.empty;
      end
    end
    if (take) begin
      kind_r <= kind_nxt;
      bits_r <= bits_nxt;
      col_r  <= col_nxt;
      row_r  <= head_word.row;
      slot_r <= slot_nxt;
      ptr_r  <= ptr_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_kind  = kind_r;
  assign out_value_bits   = bits_r;
  assign out_column_index = col_r;
  assign out_row_index    = row_r;
  assign out_slot_index   = slot_r;
  assign out_row_ptr      = ptr_r;
  assign out_last_of_item = last_r;

endmodule

@@ design/dsrc_checker.sv @@
// ----------------------------------------------------------------------------
// dsrc_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dsrc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [dsrc_pkg::KIND_W-1:0]   out_result_kind,
  input  logic [dsrc_pkg::ELEM_W-1:0]   out_value_bits,
  input  logic [dsrc_pkg::IDX_W-1:0]    out_column_index,
  input  logic [dsrc_pkg::SLOT_W-1:0]   out_slot_index,
  input  logic [dsrc_pkg::PTR_W-1:0]    out_row_ptr,
  input  logic                          out_last_of_item
);
  import dsrc_pkg::*;

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result word valid right after reset.");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_bits)
      && $stable(out_result_kind) && $stable(out_last_of_item))
    else $error("Stalled result word changed.");

  a_row_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ROW_END) |->
      (out_value_bits == '0) && (out_column_index == '0) && (out_slot_index == '0))
    else $error("Row end word carries entry fields.");

  a_diag_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_DIAG) |->
      out_last_of_item && (out_row_ptr == '0))
    else $error("Diagonal word is not the closing word of its element.");

  a_entry_no_pointer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ENTRY) |-> (out_row_ptr == '0))
    else $error("Entry word carries a row pointer.");

endmodule

bind dense_to_sparse_row_compressor_unit dsrc_checker u_dsrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_kind  (out_result_kind),
  .out_value_bits   (out_value_bits),
  .out_column_index (out_column_index),
  .out_slot_index   (out_slot_index),
  .out_row_ptr      (out_row_ptr),
  .out_last_of_item (out_last_of_item)
);
